[rtl/xadc_pkg.sv]
// ----------------------------------------------------------------------------
// xadc_pkg: shared types and microcode for the XOR output difference counter
// Step codes, jump conditions, the control word and the microcode table.
// ----------------------------------------------------------------------------
package xadc_pkg;

    // width of the result count and its saturation value
    localparam int unsigned COUNT_BITS = 9;
    localparam logic [COUNT_BITS-1:0] TALLY_MAX = 9'h1FF;

    // microprogram steps
    typedef enum logic [2:0] {
        STEP_IDLE,
        STEP_CLEAR,
        STEP_SWEEP,
        STEP_DRAIN,
        STEP_DONE
    } step_t;

    // jump conditions; a step holds until its condition is true
    typedef enum logic [2:0] {
        COND_IN_VALID,
        COND_CLR_LAST,
        COND_SWEEP_LAST,
        COND_ALWAYS,
        COND_OUT_FREE
    } cond_t;

    // one control word per step
    typedef struct packed {
        logic  in_ready;
        logic  load_diff;
        logic  clr_en;
        logic  sweep_en;
        logic  load_out;
        cond_t cond;
        step_t target;
    } ctrl_t;

    // status flags seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic clr_last;
        logic sweep_last;
        logic out_free;
    } status_t;

    // microcode table
    function automatic ctrl_t ucode_rom(input step_t step);
        ctrl_t w;
        w = '{in_ready: 1'b0, load_diff: 1'b0, clr_en: 1'b0, sweep_en: 1'b0,
              load_out: 1'b0, cond: COND_ALWAYS, target: STEP_IDLE};
        unique case (step)
            STEP_IDLE:
            begin
                w.in_ready  = 1'b1;
                w.load_diff = 1'b1;
                w.cond      = COND_IN_VALID;
                w.target    = STEP_CLEAR;
            end
            STEP_CLEAR:
            begin
                w.clr_en = 1'b1;
                w.cond   = COND_CLR_LAST;
                w.target = STEP_SWEEP;
            end
            STEP_SWEEP:
            begin
                w.sweep_en = 1'b1;
                w.cond     = COND_SWEEP_LAST;
                w.target   = STEP_DRAIN;
            end
            STEP_DRAIN:
            begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_DONE;
            end
            STEP_DONE:
            begin
                w.load_out = 1'b1;
                w.cond     = COND_OUT_FREE;
                w.target   = STEP_IDLE;
            end
            default:
            begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

[rtl/xadc_seq.sv]
// ----------------------------------------------------------------------------
// xadc_seq: microcode sequencer
// Step counter over the microcode table with conditional jumps.
// ----------------------------------------------------------------------------
module xadc_seq
(
    input  logic              clk,
    input  logic              rst_n,
    input  xadc_pkg::status_t status,
    output xadc_pkg::ctrl_t   ctrl
);
    import xadc_pkg::*;

    step_t step_reg;
    step_t step_next;
    logic  cond_true;

    // control word for the current step
    always_comb
    begin
        ctrl = ucode_rom(step_reg);
    end

    // condition select and next step
    always_comb
    begin
        unique case (ctrl.cond)
            COND_IN_VALID:   cond_true = status.in_valid;
            COND_CLR_LAST:   cond_true = status.clr_last;
            COND_SWEEP_LAST: cond_true = status.sweep_last;
            COND_OUT_FREE:   cond_true = status.out_free;
            COND_ALWAYS:     cond_true = 1'b1;
            default:         cond_true = 1'b1;
        endcase
        step_next = cond_true ? ctrl.target : step_reg;
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

[rtl/xadc_datapath.sv]
// ----------------------------------------------------------------------------
// xadc_datapath: sweep counters, difference unit, seen map and tally
// Two-stage map lookup: read issued in the first stage, mark and count in
// the second, with a bypass for a mark made in the previous cycle.
// ----------------------------------------------------------------------------
module xadc_datapath
#(
    parameter int unsigned WORD_BITS = 8
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  xadc_pkg::ctrl_t                 ctrl,
    input  logic                            start,
    input  logic [7:0]                      diff_a,
    input  logic [7:0]                      diff_b,
    output logic                            clr_last,
    output logic                            sweep_last,
    output logic [xadc_pkg::COUNT_BITS-1:0] tally
);
    import xadc_pkg::*;

    localparam int unsigned DEPTH = 1 << WORD_BITS;

    // differences reduced to the word size
    logic [WORD_BITS+7:0]    da_ext;
    logic [WORD_BITS+7:0]    db_ext;
    logic [WORD_BITS-1:0]    da_reg;
    logic [WORD_BITS-1:0]    db_reg;

    logic [WORD_BITS-1:0]    clr_ptr_reg;
    logic [WORD_BITS-1:0]    clr_ptr_next;
    logic [WORD_BITS-1:0]    first_reg;
    logic [WORD_BITS-1:0]    first_next;
    logic [WORD_BITS-1:0]    second_reg;
    logic [WORD_BITS-1:0]    second_next;

    logic [WORD_BITS-1:0]    a2;
    logic [WORD_BITS-1:0]    b2;
    logic [WORD_BITS-1:0]    dx;

    logic                    s2_vld_reg;
    logic [WORD_BITS-1:0]    dx_q_reg;
    logic                    rd_reg;
    logic                    pend_vld_reg;
    logic [WORD_BITS-1:0]    pend_addr_reg;
    logic                    seen;
    logic                    mark;

    logic [COUNT_BITS-1:0]   tally_reg;
    logic [COUNT_BITS-1:0]   tally_next;

    logic                    map_we;
    logic [WORD_BITS-1:0]    map_waddr;
    logic                    map_mem [0:DEPTH-1];

    assign da_ext = {{WORD_BITS{1'b0}}, diff_a};
    assign db_ext = {{WORD_BITS{1'b0}}, diff_b};

    // latch the differences of a new request
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            da_reg <= da_ext[WORD_BITS-1:0];
            db_reg <= db_ext[WORD_BITS-1:0];
        end
    end

    // clear pointer and operand sweep counters
    assign clr_last   = &clr_ptr_reg;
    assign sweep_last = (&first_reg) & (&second_reg);

    always_comb
    begin
        clr_ptr_next = clr_ptr_reg;
        first_next   = first_reg;
        second_next  = second_reg;
        if (ctrl.clr_en)
        begin
            clr_ptr_next = clr_ptr_reg + 1'b1;
        end
        if (ctrl.sweep_en)
        begin
            second_next = second_reg + 1'b1;
            if (&second_reg)
            begin
                first_next = first_reg + 1'b1;
            end
        end
    end

    // output difference of the current pair
    assign a2 = first_reg + da_reg;
    assign b2 = second_reg + db_reg;
    assign dx = (a2 ^ b2) - (first_reg ^ second_reg);

    // second stage: new when neither the map nor last cycle's mark has it
    assign seen = rd_reg | (pend_vld_reg && (pend_addr_reg == dx_q_reg));
    assign mark = s2_vld_reg && !seen;

    always_comb
    begin
        tally_next = tally_reg;
        if (start)
        begin
            tally_next = '0;
        end
        else if (mark && (tally_reg < TALLY_MAX))
        begin
            tally_next = tally_reg + 1'b1;
        end
    end

    assign tally = tally_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_ptr_reg  <= '0;
            first_reg    <= '0;
            second_reg   <= '0;
            s2_vld_reg   <= 1'b0;
            pend_vld_reg <= 1'b0;
            tally_reg    <= '0;
        end
        else
        begin
            clr_ptr_reg  <= clr_ptr_next;
            first_reg    <= first_next;
            second_reg   <= second_next;
            s2_vld_reg   <= ctrl.sweep_en;
            pend_vld_reg <= mark;
            tally_reg    <= tally_next;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        dx_q_reg      <= dx;
        pend_addr_reg <= dx_q_reg;
    end

    // seen map: one write port, registered read
    assign map_we    = ctrl.clr_en | mark;
    assign map_waddr = ctrl.clr_en ? clr_ptr_reg : dx_q_reg;

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= !ctrl.clr_en;
        end
        rd_reg <= map_mem[dx];
    end

endmodule

[rtl/xor_add_diff_output_count_unit.sv]
// ----------------------------------------------------------------------------
// xor_add_diff_output_count_unit: distinct XOR output additive differences
// Counts the distinct values of ((a+da)^(b+db)) - (a^b) over all word pairs.
// ----------------------------------------------------------------------------
// One request starts with a clearing pass over the seen map; then one
// operand pair is checked per cycle through the map's single write port;
// a drain step finishes the lookup pipeline and a done step loads the
// result. The result sits in an output register, so the next request is
// taken while the previous count still waits to be read. The default
// word size is 8 bits. Differences are used modulo 2^WORD_BITS; the count
// saturates at 511.
module xor_add_diff_output_count_unit
#(
    parameter int unsigned WORD_BITS = 8
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      diff_a,
    input  logic [7:0]                      diff_b,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [xadc_pkg::COUNT_BITS-1:0] distinct_count
);
    import xadc_pkg::*;

    ctrl_t                 ctrl;
    status_t               status;
    logic                  start;
    logic                  clr_last;
    logic                  sweep_last;
    logic [COUNT_BITS-1:0] tally;
    logic                  out_free;
    logic                  out_load;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [COUNT_BITS-1:0] count_reg;

    // handshake qualifiers
    assign in_ready = ctrl.in_ready;
    assign start    = ctrl.load_diff & in_valid;
    assign out_free = !out_valid_reg || out_ready;
    assign out_load = ctrl.load_out & out_free;

    assign status = '{in_valid: in_valid, clr_last: clr_last,
                      sweep_last: sweep_last, out_free: out_free};

    xadc_seq u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    xadc_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .start      (start),
        .diff_a     (diff_a),
        .diff_b     (diff_b),
        .clr_last   (clr_last),
        .sweep_last (sweep_last),
        .tally      (tally)
    );

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            count_reg <= tally;
        end
    end

    assign out_valid      = out_valid_reg;
    assign distinct_count = count_reg;

endmodule
